// ----- sv/slx_pkg.sv -----
// shared types, codes and keyword tables for the sql token lexer
package slx_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int MAX_RESULTS = 3;

   // result kinds
   localparam logic [1:0] KIND_TEXT = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;
   localparam logic [1:0] KIND_EOS  = 2'd3;

   // token types
   localparam logic [3:0] TYPE_IDENT  = 4'd0;
   localparam logic [3:0] TYPE_NUMBER = 4'd1;
   localparam logic [3:0] TYPE_STRING = 4'd2;
   localparam logic [3:0] TYPE_COMMA  = 4'd3;
   localparam logic [3:0] TYPE_LPAREN = 4'd4;
   localparam logic [3:0] TYPE_RPAREN = 4'd5;
   localparam logic [3:0] TYPE_SEMI   = 4'd6;
   localparam logic [3:0] TYPE_STAR   = 4'd7;
   localparam logic [3:0] TYPE_EQUAL  = 4'd8;
   localparam logic [3:0] TYPE_KW0    = 4'd9;
   localparam logic [3:0] TYPE_EOF    = 4'd15;

   // error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_CHAR    = 2'd1;
   localparam logic [1:0] ERR_NUMBER  = 2'd2;
   localparam logic [1:0] ERR_UNTERM  = 2'd3;

   localparam int NUM_KEYWORDS = 6;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] tok_type;
      logic [7:0] ch;
      logic [1:0] err;
   } slx_result_type;

   // all results caused by one input byte, in order
   typedef struct packed {
      logic [1:0]                            num;
      slx_result_type [MAX_RESULTS-1:0]      res;
   } slx_bundle_type;

   // keyword text, left aligned, zero padded
   function automatic logic [47:0] kw_word(input logic [2:0] k);
      logic [47:0] w;
      unique case (k)
         3'd0:    w = "INSERT";
         3'd1:    w = {"INTO", 16'h0000};
         3'd2:    w = "VALUES";
         3'd3:    w = "SELECT";
         3'd4:    w = {"FROM", 16'h0000};
         3'd5:    w = {"WHERE", 8'h00};
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
      logic [47:0] tmp;
      tmp = kw_word(k) << {pos, 3'b000};
      return tmp[47:40];
   endfunction

   function automatic logic [2:0] kw_len(input logic [2:0] k);
      logic [2:0] l;
      unique case (k)
         3'd1, 3'd4: l = 3'd4;
         3'd5:       l = 3'd5;
         default:    l = 3'd6;
      endcase
      return l;
   endfunction

endpackage

// ----- sv/slx_front.sv -----
// lexer front end: takes one byte a beat and builds its result bundle
module slx_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_in_char,
   output logic                   push,
   output slx_pkg::slx_bundle_type push_bundle,
   input  logic                   push_ready
);
   import slx_pkg::*;

   localparam logic [2:0] M_IDLE   = 3'd0;
   localparam logic [2:0] M_IDENT  = 3'd1;
   localparam logic [2:0] M_NUMBER = 3'd2;
   localparam logic [2:0] M_MINUS  = 3'd3;
   localparam logic [2:0] M_DOT    = 3'd4;
   localparam logic [2:0] M_STRING = 3'd5;
   localparam logic [2:0] M_QUOTE  = 3'd6;
   localparam logic [2:0] M_DROP   = 3'd7;

   logic [2:0] mode_ff, mode_in;
   logic [5:0] flags_ff, flags_in;
   logic [2:0] len_ff, len_in;
   logic       dot_ff, dot_in;
   logic       accept;

   slx_result_type [MAX_RESULTS-1:0] res_v;
   logic [1:0]                       num_v;

   function automatic slx_result_type mk(input logic [1:0] kind, input logic [3:0] t,
                                         input logic [7:0] ch, input logic [1:0] err);
      slx_result_type r;
      r.kind     = kind;
      r.tok_type = t;
      r.ch       = ch;
      r.err      = err;
      return r;
   endfunction

   function automatic logic [5:0] kw_update(input logic [5:0] flags, input logic [2:0] len,
                                            input logic [7:0] up);
      logic [5:0] f;
      f = flags;
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         if (f[k] && (len >= kw_len(3'(k)) || kw_char(3'(k), len) != up)) begin
            f[k] = 1'b0;
         end
      end
      return f;
   endfunction

   function automatic logic [3:0] ident_type(input logic [5:0] flags, input logic [2:0] len);
      logic [3:0] t;
      t = TYPE_IDENT;
      for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
         if (flags[k] && len == kw_len(3'(k))) begin
            t = TYPE_KW0 + 4'(k);
         end
      end
      return t;
   endfunction

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic [7:0] c;
      logic [7:0] up;
      logic       fresh;
      logic       is_digit, is_alpha, is_space, is_ident;
      logic [3:0] sym;

      c        = req_in_char;
      up       = (c >= "a" && c <= "z") ? c - 8'd32 : c;
      is_digit = (c >= "0" && c <= "9");
      is_alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
      is_ident = is_alpha || is_digit || c == "_";
      unique case (c)
         ",":     sym = TYPE_COMMA;
         "(":     sym = TYPE_LPAREN;
         ")":     sym = TYPE_RPAREN;
         ";":     sym = TYPE_SEMI;
         "*":     sym = TYPE_STAR;
         "=":     sym = TYPE_EQUAL;
         default: sym = TYPE_IDENT;
      endcase

      mode_in  = mode_ff;
      flags_in = flags_ff;
      len_in   = len_ff;
      dot_in   = dot_ff;
      res_v    = '0;
      num_v    = 2'd0;
      fresh    = 1'b0;

      unique case (mode_ff)
         M_IDENT: begin
            if (is_ident) begin
               flags_in = kw_update(flags_ff, len_ff, up);
               if (len_ff != 3'd7) len_in = len_ff + 3'd1;
               res_v[num_v] = mk(KIND_TEXT, TYPE_IDENT, c, ERR_NONE);
               num_v = num_v + 2'd1;
            end else begin
               res_v[num_v] = mk(KIND_END, ident_type(flags_ff, len_ff), 8'd0, ERR_NONE);
               num_v = num_v + 2'd1;
               fresh = 1'b1;
            end
         end
         M_NUMBER: begin
            if (is_digit) begin
               res_v[num_v] = mk(KIND_TEXT, TYPE_IDENT, c, ERR_NONE);
               num_v = num_v + 2'd1;
            end else if (c == "." && !dot_ff) begin
               mode_in = M_DOT;
            end else begin
               res_v[num_v] = mk(KIND_END, TYPE_NUMBER, 8'd0, ERR_NONE);
               num_v = num_v + 2'd1;
               fresh = 1'b1;
            end
         end
         M_DOT, M_MINUS: begin
            if (is_digit) begin
               res_v[0] = mk(KIND_TEXT, TYPE_IDENT, (mode_ff == M_DOT) ? 8'(".") : 8'("-"),
                             ERR_NONE);
               res_v[1] = mk(KIND_TEXT, TYPE_IDENT, c, ERR_NONE);
               num_v    = 2'd2;
               dot_in   = (mode_ff == M_DOT);
               mode_in  = M_NUMBER;
            end else begin
               res_v[0] = mk(KIND_ERR, TYPE_IDENT, 8'd0,
                             (mode_ff == M_DOT) ? ERR_NUMBER : ERR_CHAR);
               num_v    = 2'd1;
               mode_in  = (c == 8'd0) ? M_IDLE : M_DROP;
            end
         end
         M_STRING: begin
            if (c == 8'd0) begin
               res_v[0] = mk(KIND_ERR, TYPE_IDENT, 8'd0, ERR_UNTERM);
               num_v    = 2'd1;
               mode_in  = M_IDLE;
            end else if (c == "'") begin
               mode_in = M_QUOTE;
            end else begin
               res_v[0] = mk(KIND_TEXT, TYPE_IDENT, c, ERR_NONE);
               num_v    = 2'd1;
            end
         end
         M_QUOTE: begin
            if (c == "'") begin
               res_v[0] = mk(KIND_TEXT, TYPE_IDENT, c, ERR_NONE);
               num_v    = 2'd1;
               mode_in  = M_STRING;
            end else begin
               res_v[0] = mk(KIND_END, TYPE_STRING, 8'd0, ERR_NONE);
               num_v    = 2'd1;
               fresh    = 1'b1;
            end
         end
         M_DROP: begin
            if (c == 8'd0) mode_in = M_IDLE;
         end
         default: begin
            fresh = 1'b1;
         end
      endcase

      // byte handled as the start of a new token
      if (fresh) begin
         mode_in = M_IDLE;
         if (c == 8'd0) begin
            res_v[num_v] = mk(KIND_EOS, TYPE_EOF, 8'd0, ERR_NONE);
            num_v = num_v + 2'd1;
         end else if (is_space) begin
            mode_in = M_IDLE;
         end else if (is_alpha || c == "_") begin
            mode_in  = M_IDENT;
            flags_in = kw_update(6'h3f, 3'd0, up);
            len_in   = 3'd1;
            res_v[num_v] = mk(KIND_TEXT, TYPE_IDENT, c, ERR_NONE);
            num_v = num_v + 2'd1;
         end else if (is_digit) begin
            mode_in = M_NUMBER;
            dot_in  = 1'b0;
            res_v[num_v] = mk(KIND_TEXT, TYPE_IDENT, c, ERR_NONE);
            num_v = num_v + 2'd1;
         end else if (c == "-") begin
            mode_in = M_MINUS;
         end else if (c == "'") begin
            mode_in = M_STRING;
         end else if (sym != TYPE_IDENT) begin
            res_v[num_v] = mk(KIND_TEXT, TYPE_IDENT, c, ERR_NONE);
            num_v = num_v + 2'd1;
            res_v[num_v] = mk(KIND_END, sym, 8'd0, ERR_NONE);
            num_v = num_v + 2'd1;
         end else begin
            res_v[num_v] = mk(KIND_ERR, TYPE_IDENT, 8'd0, ERR_CHAR);
            num_v = num_v + 2'd1;
            mode_in = M_DROP;
         end
      end
   end

   assign push            = accept && (num_v != 2'd0);
   assign push_bundle.num = num_v;
   assign push_bundle.res = res_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         flags_ff <= 6'h3f;
         len_ff   <= 3'd0;
         dot_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         flags_ff <= flags_in;
         len_ff   <= len_in;
         dot_ff   <= dot_in;
      end
   end

endmodule

// ----- sv/slx_queue.sv -----
// short bundle queue between lexer front and result back end
module slx_queue #(
   parameter int DEPTH = slx_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  slx_pkg::slx_bundle_type push_bundle,
   output logic                    push_ready,
   input  logic                    pop,
   output logic                    pop_valid,
   output slx_pkg::slx_bundle_type pop_bundle
);
   import slx_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   slx_bundle_type mem_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_bundle = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      else if (do_pop && !do_push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_bundle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         if (do_pop)  rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
   end

endmodule

// ----- sv/slx_back.sv -----
// result back end: plays each bundle out one beat at a time
module slx_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   input  slx_pkg::slx_bundle_type pop_bundle,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_out_kind,
   output logic [3:0]              rsp_out_type,
   output logic [7:0]              rsp_out_char,
   output logic [1:0]              rsp_out_error,
   output logic                    rsp_out_last
);
   import slx_pkg::*;

   slx_bundle_type cur_ff;
   logic [1:0]     idx_ff;
   logic           busy_ff;
   slx_result_type sel;
   logic           last;

   assign sel       = cur_ff.res[idx_ff];
   assign last      = (idx_ff == cur_ff.num - 2'd1);
   assign rsp_valid = busy_ff;
   assign pop       = pop_valid && (!busy_ff || (rsp_ready && last));

   assign rsp_out_kind  = sel.kind;
   assign rsp_out_type  = sel.tok_type;
   assign rsp_out_char  = sel.ch;
   assign rsp_out_error = sel.err;
   assign rsp_out_last  = last;

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= pop_bundle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         idx_ff  <= 2'd0;
      end else if (busy_ff && rsp_ready) begin
         if (last) busy_ff <= 1'b0;
         else idx_ff <= idx_ff + 2'd1;
      end
   end

endmodule

// ----- sv/sql_token_lexer.sv -----
// streaming sql tokenizer top level: front end, bundle queue, result back end
// path: req beat -> queue memory -> back end bundle register -> rsp
// throughput: one req byte per cycle unless the queue is full; one rsp beat
//   per cycle with rsp_ready; the queue absorbs a byte's burst of n results
// reset: synchronous, active high; lexer idles between tokens, queue empties
// the front end stalls only when the queue is full
module sql_token_lexer #(
   parameter int QUEUE_DEPTH = slx_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_out_kind,
   output logic [3:0] rsp_out_type,
   output logic [7:0] rsp_out_char,
   output logic [1:0] rsp_out_error,
   output logic       rsp_out_last
);
   import slx_pkg::*;

   // front to queue
   logic           push, push_ready;
   slx_bundle_type push_bundle;
   // queue to back
   logic           pop, pop_valid;
   slx_bundle_type pop_bundle;

   // lexer state machine; turns every accepted byte into zero to three results
   slx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_char (req_in_char),
      .push        (push),
      .push_bundle (push_bundle),
      .push_ready  (push_ready)
   );

   // bytes with no results (whitespace, dropped bytes) never enter the queue
   slx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .push_ready  (push_ready),
      .pop         (pop),
      .pop_valid   (pop_valid),
      .pop_bundle  (pop_bundle)
   );

   // serializer; the next bundle loads in the same cycle the last beat leaves
   slx_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_bundle    (pop_bundle),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_out_type  (rsp_out_type),
      .rsp_out_char  (rsp_out_char),
      .rsp_out_error (rsp_out_error),
      .rsp_out_last  (rsp_out_last)
   );

endmodule

// ----- sv/slx_checker.sv -----
// port level checks for the sql token lexer, bound to the top level
module slx_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_out_kind,
   input logic [3:0] rsp_out_type,
   input logic [7:0] rsp_out_char,
   input logic [1:0] rsp_out_error,
   input logic       rsp_out_last
);
   import slx_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_kind) &&
      $stable(rsp_out_type) && $stable(rsp_out_char) && $stable(rsp_out_error) &&
      $stable(rsp_out_last))
      else $error("rsp beat changed while stalled");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // an error ends the byte's results and carries a code
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_ERR |-> rsp_out_last && rsp_out_error != ERR_NONE &&
      rsp_out_type == TYPE_IDENT && rsp_out_char == 8'd0)
      else $error("malformed error beat");

   // end of statement is always the last beat of byte 0
   a_eos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_EOS |-> rsp_out_last && rsp_out_type == TYPE_EOF &&
      rsp_out_char == 8'd0 && rsp_out_error == ERR_NONE)
      else $error("malformed end of statement beat");

   // text beats carry no type or error
   a_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_TEXT |-> rsp_out_type == TYPE_IDENT &&
      rsp_out_error == ERR_NONE)
      else $error("malformed text beat");

endmodule

bind sql_token_lexer slx_checker u_checker (.*);

// ----- tb/sql_token_lexer_test.sv -----
// self-checking testbench for the streaming sql token lexer
`timescale 1ns / 1ps

module sql_token_lexer_test;
   import slx_pkg::*;

   // one rsp beat as the block presents it
   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] ttype;
      logic [7:0] ch;
      logic [1:0] err;
      logic       last;
   } lex_beat_type;

   // one row of the directed table; typed rows carry their expected beat
   typedef struct {
      logic [7:0] ch;
      bit         typed;
      int         n;
      logic [1:0] kind;
      logic [3:0] ttype;
      logic [1:0] err;
   } stim_row_type;

   // scanner modes of the predictor
   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_MINUS,
      SCAN_DOT, SCAN_STRING, SCAN_QUOTE, SCAN_DROP
   } scan_mode_type;

   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_MINUS = "-";
   localparam logic [7:0] CH_DOT   = ".";
   localparam logic [7:0] CH_UNDER = "_";
   localparam logic [7:0] CH_EOS   = 8'h00;

   // keyword spellings, keyword k in bits [k*48 +: 48], first letter on top
   localparam logic [6*48-1:0] KW_TEXT = {
      "WHERE", 8'h00, "FROM", 16'h0000, "SELECT", "VALUES", "INTO", 16'h0000, "INSERT"
   };
   localparam logic [6*3-1:0]  KW_LENS = {3'd5, 3'd4, 3'd6, 3'd6, 3'd4, 3'd6};
   localparam logic [6*8-1:0]  SYMBOLS = ",()*;=";

   localparam int DIRECTED_ROWS = 27;
   localparam int PHASE_BYTES   = 170;
   localparam int DRAIN_LIMIT   = 20000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_char = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_out_kind;
   logic [3:0] rsp_out_type;
   logic [7:0] rsp_out_char;
   logic [1:0] rsp_out_error;
   logic       rsp_out_last;

   // predictor state
   scan_mode_type scan_mode;
   logic [5:0]    kw_alive;
   logic [2:0]    word_len;
   logic          num_has_dot;

   lex_beat_type step_beats[$];      // beats caused by the byte just accepted
   lex_beat_type expected_beats[$];  // beats still owed by the block
   logic [7:0]   stmt_bytes[$];      // one generated statement
   stim_row_type dir_table [DIRECTED_ROWS];

   int send_idle_pct = 18;
   int recv_idle_pct = 49;
   int live_bytes;
   int mismatch_count = 0;

   sql_token_lexer dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_char   (req_in_char),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_out_type  (rsp_out_type),
      .rsp_out_char  (rsp_out_char),
      .rsp_out_error (rsp_out_error),
      .rsp_out_last  (rsp_out_last)
   );

   // 20 ns clock, rising edges at 10, 30, ...
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // character classes
   // ------------------------------------------------------------------
   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_word_char(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == CH_UNDER;
   endfunction

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   task automatic emit_beat(input logic [1:0] kind, input logic [3:0] ttype,
                            input logic [7:0] ch, input logic [1:0] err);
      lex_beat_type b;
      b.kind  = kind;
      b.ttype = ttype;
      b.ch    = ch;
      b.err   = err;
      b.last  = 1'b0;
      step_beats.push_back(b);
   endtask

   // any error sends the scanner to drop mode, unless the byte was the end itself
   task automatic raise_error(input logic [1:0] code, input logic [7:0] c);
      emit_beat(KIND_ERR, TYPE_IDENT, 8'h00, code);
      scan_mode = (c == CH_EOS) ? SCAN_IDLE : SCAN_DROP;
   endtask

   // one more identifier letter: knock out keywords that no longer fit
   task automatic take_word_char(input logic [7:0] c);
      logic [7:0] up;
      int         pos;
      up  = (c >= "a" && c <= "z") ? c - 8'd32 : c;
      pos = word_len;
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         if (kw_alive[k]) begin
            if (pos >= KW_LENS[k*3 +: 3])
               kw_alive[k] = 1'b0;
            else if (KW_TEXT[k*48 + 47 - 8*pos -: 8] != up)
               kw_alive[k] = 1'b0;
         end
      end
      if (word_len != 3'd7) word_len = word_len + 3'd1;
      emit_beat(KIND_TEXT, TYPE_IDENT, c, ERR_NONE);
   endtask

   // byte seen between tokens
   task automatic begin_token(input logic [7:0] c);
      logic [3:0] st;
      scan_mode = SCAN_IDLE;
      if (c == CH_EOS) begin
         emit_beat(KIND_EOS, TYPE_EOF, 8'h00, ERR_NONE);
      end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
         // whitespace, nothing
      end else if (is_alpha(c) || c == CH_UNDER) begin
         scan_mode = SCAN_WORD;
         kw_alive  = 6'h3f;
         word_len  = 3'd0;
         take_word_char(c);
      end else if (is_digit(c)) begin
         scan_mode   = SCAN_NUMBER;
         num_has_dot = 1'b0;
         emit_beat(KIND_TEXT, TYPE_IDENT, c, ERR_NONE);
      end else if (c == CH_MINUS) begin
         scan_mode = SCAN_MINUS;
      end else if (c == CH_QUOTE) begin
         scan_mode = SCAN_STRING;
      end else begin
         case (c)
            ",":     st = TYPE_COMMA;
            "(":     st = TYPE_LPAREN;
            ")":     st = TYPE_RPAREN;
            ";":     st = TYPE_SEMI;
            "*":     st = TYPE_STAR;
            "=":     st = TYPE_EQUAL;
            default: st = TYPE_IDENT;
         endcase
         if (st != TYPE_IDENT) begin
            emit_beat(KIND_TEXT, TYPE_IDENT, c, ERR_NONE);
            emit_beat(KIND_END, st, 8'h00, ERR_NONE);
         end else begin
            raise_error(ERR_CHAR, c);
         end
      end
   endtask

   // all beats caused by one accepted byte land in step_beats
   task automatic lex_predict(input logic [7:0] c);
      logic [3:0] wt;
      step_beats.delete();
      case (scan_mode)
         SCAN_WORD: begin
            if (is_word_char(c)) begin
               take_word_char(c);
            end else begin
               wt = TYPE_IDENT;
               for (int k = NUM_KEYWORDS - 1; k >= 0; k--)
                  if (kw_alive[k] && word_len == KW_LENS[k*3 +: 3]) wt = TYPE_KW0 + 4'(k);
               emit_beat(KIND_END, wt, 8'h00, ERR_NONE);
               begin_token(c);
            end
         end
         SCAN_NUMBER: begin
            if (is_digit(c)) begin
               emit_beat(KIND_TEXT, TYPE_IDENT, c, ERR_NONE);
            end else if (c == CH_DOT && !num_has_dot) begin
               scan_mode = SCAN_DOT;
            end else begin
               emit_beat(KIND_END, TYPE_NUMBER, 8'h00, ERR_NONE);
               begin_token(c);
            end
         end
         SCAN_DOT: begin
            if (is_digit(c)) begin
               emit_beat(KIND_TEXT, TYPE_IDENT, CH_DOT, ERR_NONE);
               emit_beat(KIND_TEXT, TYPE_IDENT, c, ERR_NONE);
               num_has_dot = 1'b1;
               scan_mode   = SCAN_NUMBER;
            end else begin
               raise_error(ERR_NUMBER, c);
            end
         end
         SCAN_MINUS: begin
            if (is_digit(c)) begin
               emit_beat(KIND_TEXT, TYPE_IDENT, CH_MINUS, ERR_NONE);
               emit_beat(KIND_TEXT, TYPE_IDENT, c, ERR_NONE);
               num_has_dot = 1'b0;
               scan_mode   = SCAN_NUMBER;
            end else begin
               raise_error(ERR_CHAR, c);
            end
         end
         SCAN_STRING: begin
            if (c == CH_EOS)        raise_error(ERR_UNTERM, c);
            else if (c == CH_QUOTE) scan_mode = SCAN_QUOTE;
            else                    emit_beat(KIND_TEXT, TYPE_IDENT, c, ERR_NONE);
         end
         SCAN_QUOTE: begin
            if (c == CH_QUOTE) begin
               emit_beat(KIND_TEXT, TYPE_IDENT, CH_QUOTE, ERR_NONE);
               scan_mode = SCAN_STRING;
            end else begin
               emit_beat(KIND_END, TYPE_STRING, 8'h00, ERR_NONE);
               begin_token(c);
            end
         end
         SCAN_DROP: begin
            if (c == CH_EOS) scan_mode = SCAN_IDLE;
         end
         default: begin
            begin_token(c);
         end
      endcase
      if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // req side: present one byte, hold it until the beat, then book results
   // ------------------------------------------------------------------
   task automatic drive_byte(input logic [7:0] c, input bit typed, input int n_typed,
                             input lex_beat_type typed_beat);
      // random gap with valid low, one assignment per falling edge
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_char <= c;
      do @(posedge clock); while (req_ready !== 1'b1);
      // bytes swallowed in drop mode do not count toward the phase length
      if (scan_mode != SCAN_DROP) live_bytes++;
      lex_predict(c);
      // typed rows: predictor only advances its state, the table gives the beat
      if (typed) begin
         if (n_typed > 0) expected_beats.push_back(typed_beat);
      end else begin
         foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
      end
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // random statement builder
   // ------------------------------------------------------------------
   function automatic logic [7:0] rand_space();
      int r;
      r = $urandom_range(5);
      return (r == 5) ? 8'h20 : 8'd9 + r[7:0];
   endfunction

   function automatic logic [7:0] rand_digit();
      int r;
      r = $urandom_range(9);
      return 8'd48 + r[7:0];
   endfunction

   function automatic logic [7:0] rand_word_char(input bit lead);
      int r;
      r = lead ? $urandom_range(52) : $urandom_range(62);
      if (r < 26)       return 8'd65 + r[7:0];
      else if (r < 52)  return 8'd97 + r[7:0] - 8'd26;
      else if (r == 52) return CH_UNDER;
      else              return 8'd48 + r[7:0] - 8'd53;
   endfunction

   // mostly well formed statements with random content, some broken tokens
   task automatic build_statement();
      int         ntok;
      int         pick;
      int         k;
      int         len;
      int         r;
      logic [7:0] b;
      stmt_bytes.delete();
      ntok = $urandom_range(6);
      for (int t = 0; t < ntok; t++) begin
         // separator, sometimes tokens butt against each other
         if ($urandom_range(99) < 70)
            repeat ($urandom_range(1, 2)) stmt_bytes.push_back(rand_space());
         pick = $urandom_range(99);
         if (pick < 20) begin
            // keyword in mixed case, now and then extended into an identifier
            k   = $urandom_range(NUM_KEYWORDS - 1);
            len = KW_LENS[k*3 +: 3];
            for (int i = 0; i < len; i++) begin
               b = KW_TEXT[k*48 + 47 - 8*i -: 8];
               if ($urandom_range(1)) b = b | 8'h20;
               stmt_bytes.push_back(b);
            end
            if ($urandom_range(9) == 0) stmt_bytes.push_back(rand_word_char(1'b0));
         end else if (pick < 35) begin
            // identifier, long enough at times to saturate the length count
            stmt_bytes.push_back(rand_word_char(1'b1));
            repeat ($urandom_range(8)) stmt_bytes.push_back(rand_word_char(1'b0));
         end else if (pick < 55) begin
            if ($urandom_range(3) == 0) stmt_bytes.push_back(CH_MINUS);
            repeat ($urandom_range(1, 4)) stmt_bytes.push_back(rand_digit());
            if ($urandom_range(9) < 3) begin
               stmt_bytes.push_back(CH_DOT);
               repeat ($urandom_range(1, 3)) stmt_bytes.push_back(rand_digit());
            end
         end else if (pick < 70) begin
            // string with any nonzero content, quotes doubled
            stmt_bytes.push_back(CH_QUOTE);
            repeat ($urandom_range(5)) begin
               r = $urandom_range(1, 255);
               stmt_bytes.push_back(r[7:0]);
               if (r[7:0] == CH_QUOTE) stmt_bytes.push_back(CH_QUOTE);
            end
            stmt_bytes.push_back(CH_QUOTE);
         end else if (pick < 90) begin
            r = $urandom_range(5);
            stmt_bytes.push_back(SYMBOLS[8*r +: 8]);
         end else begin
            case ($urandom_range(4))
               0: begin
                  // lone minus
                  stmt_bytes.push_back(CH_MINUS);
                  stmt_bytes.push_back(rand_word_char(1'b1));
               end
               1: begin
                  // dot with no digit after it
                  stmt_bytes.push_back(rand_digit());
                  stmt_bytes.push_back(CH_DOT);
                  stmt_bytes.push_back(rand_space());
               end
               2: begin
                  // second dot in a number
                  stmt_bytes.push_back(rand_digit());
                  stmt_bytes.push_back(CH_DOT);
                  stmt_bytes.push_back(rand_digit());
                  stmt_bytes.push_back(CH_DOT);
               end
               3: begin
                  // open quote, usually left unterminated at the end byte
                  stmt_bytes.push_back(CH_QUOTE);
                  stmt_bytes.push_back(rand_word_char(1'b0));
               end
               default: begin
                  r = $urandom_range(1, 255);
                  stmt_bytes.push_back(r[7:0]);
               end
            endcase
         end
      end
      if ($urandom_range(3) == 0) stmt_bytes.push_back(rand_space());
      stmt_bytes.push_back(CH_EOS);
   endtask

   // ------------------------------------------------------------------
   // rsp side: random back pressure and the checker
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // each rsp beat against the oldest expectation, field by field
   always @(posedge clock) begin : rsp_check
      lex_beat_type want;
      lex_beat_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got = {rsp_out_kind, rsp_out_type, rsp_out_char, rsp_out_error, rsp_out_last};
         if (expected_beats.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: unexpected beat kind=%0d type=%0d char=%02h err=%0d last=%0d",
                        $realtime, got.kind, got.ttype, got.ch, got.err, got.last);
            mismatch_count++;
         end else begin
            want = expected_beats.pop_front();
            if (got.kind !== want.kind || got.ttype !== want.ttype || got.ch !== want.ch ||
                got.err !== want.err || got.last !== want.last) begin
               if (mismatch_count < 10)
                  $display("%0t: mismatch exp kind=%0d type=%0d char=%02h err=%0d last=%0d %s",
                           $realtime, want.kind, want.ttype, want.ch, want.err, want.last,
                           $sformatf("got kind=%0d type=%0d char=%02h err=%0d last=%0d",
                                     got.kind, got.ttype, got.ch, got.err, got.last));
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : main_flow
      lex_beat_type tb;
      int           drain;

      scan_mode   = SCAN_IDLE;
      kw_alive    = 6'h3f;
      word_len    = 3'd0;
      num_has_dot = 1'b0;

      // directed rows: extremes, every special case, a string ending in a burst
      dir_table = '{
         '{CH_EOS,   1'b1, 1, KIND_EOS,  TYPE_EOF,   ERR_NONE},   // end right after reset
         '{8'hff,    1'b1, 1, KIND_ERR,  TYPE_IDENT, ERR_CHAR},   // top byte is junk
         '{CH_EOS,   1'b1, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},   // end of drop, silent
         '{CH_MINUS, 1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},   // held minus
         '{"1",      1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},
         '{CH_DOT,   1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},   // held dot
         '{"5",      1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},
         '{CH_DOT,   1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},   // second dot
         '{CH_EOS,   1'b1, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},
         '{CH_QUOTE, 1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},
         '{8'hff,    1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},   // top byte as content
         '{CH_QUOTE, 1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},
         '{CH_QUOTE, 1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},   // doubled quote
         '{CH_QUOTE, 1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},
         '{")",      1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},   // three beats
         '{"W",      1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},
         '{"h",      1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},
         '{"*",      1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},
         '{"7",      1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},
         '{CH_DOT,   1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},
         '{"=",      1'b1, 1, KIND_ERR,  TYPE_IDENT, ERR_NUMBER}, // dot with no digit
         '{CH_EOS,   1'b1, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},
         '{CH_QUOTE, 1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},
         '{CH_EOS,   1'b1, 1, KIND_ERR,  TYPE_IDENT, ERR_UNTERM}, // open string at end
         '{CH_MINUS, 1'b0, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE},
         '{" ",      1'b1, 1, KIND_ERR,  TYPE_IDENT, ERR_CHAR},   // lone minus
         '{CH_EOS,   1'b1, 0, KIND_TEXT, TYPE_IDENT, ERR_NONE}
      };

      // single reset pulse, released on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part under the first idling mix
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         tb = '{kind: dir_table[i].kind, ttype: dir_table[i].ttype, ch: 8'h00,
                err: dir_table[i].err, last: 1'b1};
         drive_byte(dir_table[i].ch, dir_table[i].typed, dir_table[i].n, tb);
      end

      // random part in three idling mixes: sender light, receiver light, none
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 18; recv_idle_pct = 49; end
            1:       begin send_idle_pct = 49; recv_idle_pct = 18; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         live_bytes = 0;
         while (live_bytes < PHASE_BYTES) begin
            build_statement();
            foreach (stmt_bytes[j]) drive_byte(stmt_bytes[j], 1'b0, 0, '0);
         end
      end
      req_valid <= 1'b0;

      // drain, then keep watching for anything stray
      drain = 0;
      while (expected_beats.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (expected_beats.size() != 0) begin
         $display("%0d expected beats never arrived", expected_beats.size());
         mismatch_count += expected_beats.size();
      end

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // hard stop far beyond the slowest legal run
   initial begin : watchdog
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/slx_pkg.sv
sv/slx_front.sv
sv/slx_queue.sv
sv/slx_back.sv
sv/sql_token_lexer.sv
sv/slx_checker.sv
tb/sql_token_lexer_test.sv
